// ===== rtl/hbca_pkg.sv =====
// Package for the HSL band color adjust unit: payload structs, hue circle
// constants, band centers and fixed reciprocals. Depends on nothing.
`timescale 1ns / 1ps

package hbca_pkg;

  localparam int NUM_BANDS = 8;

  // Hue in 1/64 degree steps
  localparam int TURN           = 23040;
  localparam int HALF_TURN      = 11520;
  localparam int BAND_REACH     = 1920;
  localparam int HUE_SECTOR     = 3840;
  localparam int HUE_THIRD      = 7680;
  localparam int HUE_TWO_THIRDS = 15360;

  localparam int ONE_Q16  = 65536;
  localparam int HALF_Q16 = 32768;
  localparam int CHAN_MAX = 255;

  // Band offset scaling: hue rdiv(off*w, 30), levels rdiv(4*off*w, 15)
  localparam int HUE_STEP_DIV   = 30;
  localparam int LEVEL_STEP_DIV = 15;

  // Reciprocals: floor-based with correction, or ceil-based exact in range
  localparam int RCP_K     = 25;
  localparam int RCP_255   = (1 << RCP_K) / CHAN_MAX;
  localparam int RCP_SH    = 26;
  localparam int RCP_30    = ((1 << RCP_SH) + HUE_STEP_DIV - 1) / HUE_STEP_DIV;
  localparam int RCP_15    = ((1 << RCP_SH) + LEVEL_STEP_DIV - 1) / LEVEL_STEP_DIV;

  localparam logic [14:0] BAND_CENTER [NUM_BANDS] = '{
    15'd0, 15'd1920, 15'd3840, 15'd7680, 15'd11520, 15'd13440, 15'd17280, 15'd19200
  };

  typedef enum logic [1:0] {
    CFG_HUE,
    CFG_SAT,
    CFG_LIT
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } rgb_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } rgb_out_t;

  // Hue kept in 0..TURN-1, saturation and lightness signed Q5.16
  typedef struct packed {
    logic [14:0]        hue;
    logic signed [21:0] sat;
    logic signed [21:0] lit;
  } hsl_t;

endpackage

// ===== rtl/hbca_rgb2hsl.sv =====
// RGB to HSL front end: four pipeline stages with reciprocal-table division.
// Depends on hbca_pkg.
`timescale 1ns / 1ps

module hbca_rgb2hsl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hbca_pkg::rgb_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hbca_pkg::hsl_t   out_data_o
);
  import hbca_pkg::*;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  logic [3:0] v_q;
  logic [3:0] en;

  logic [25:0] rcp_tab [256];

  assign rcp_tab[0] = '0;
  for (genvar g = 1; g < 256; g++) begin : g_rcp
    localparam int RV = (1 << RCP_K) / g;
    assign rcp_tab[g] = 26'(RV);
  end

  always_comb begin
    en[3] = !v_q[3] || out_ready_i;
    en[2] = !v_q[2] || en[3];
    en[1] = !v_q[1] || en[2];
    en[0] = !v_q[0] || en[1];
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
    end
  end

  // Stage 1: extremes, sector, dividends and reciprocal lookup
  logic [7:0]        mx, mn, dd, den, hmag;
  logic [8:0]        sum;
  logic signed [8:0] hdiff;
  sector_e           sec_d;

  always_comb begin
    mx = in_data_i.red_in;
    mn = in_data_i.red_in;
    if (in_data_i.green_in > mx) mx = in_data_i.green_in;
    if (in_data_i.blue_in > mx)  mx = in_data_i.blue_in;
    if (in_data_i.green_in < mn) mn = in_data_i.green_in;
    if (in_data_i.blue_in < mn)  mn = in_data_i.blue_in;
    dd  = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    den = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
    if (mx == in_data_i.red_in) begin
      sec_d = SEC_RED;
      hdiff = $signed({1'b0, in_data_i.green_in}) - $signed({1'b0, in_data_i.blue_in});
    end else if (mx == in_data_i.green_in) begin
      sec_d = SEC_GREEN;
      hdiff = $signed({1'b0, in_data_i.blue_in}) - $signed({1'b0, in_data_i.red_in});
    end else begin
      sec_d = SEC_BLUE;
      hdiff = $signed({1'b0, in_data_i.red_in}) - $signed({1'b0, in_data_i.green_in});
    end
    hmag = hdiff[8] ? 8'(-hdiff) : hdiff[7:0];
  end

  logic        zero1_q, neg1_q;
  sector_e     sec1_q;
  logic [7:0]  d1_q, den1_q;
  logic [24:0] xs1_q;
  logic [20:0] xh1_q;
  logic [23:0] yl1_q;
  logic [25:0] rs1_q, rh1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      zero1_q <= (dd == 8'd0);
      neg1_q  <= hdiff[8];
      sec1_q  <= sec_d;
      d1_q    <= dd;
      den1_q  <= den;
      xs1_q   <= {dd, 17'd0};
      xh1_q   <= 21'(hmag) * 21'(HUE_THIRD);
      // (sum*65536 + 255) / 510 equals (sum*32768 + 127) / 255
      yl1_q   <= {sum, 15'd127};
      rs1_q   <= rcp_tab[den];
      rh1_q   <= rcp_tab[dd];
    end
  end

  // Stage 2: reciprocal multiply, quotient low by at most one
  logic [50:0] prod_s;
  logic [46:0] prod_h;
  logic [41:0] prod_l;

  assign prod_s = 51'(xs1_q) * 51'(rs1_q);
  assign prod_h = 47'(xh1_q) * 47'(rh1_q);
  assign prod_l = 42'(yl1_q) * 42'(RCP_255);

  logic        zero2_q, neg2_q;
  sector_e     sec2_q;
  logic [7:0]  d2_q, den2_q;
  logic [24:0] xs2_q;
  logic [20:0] xh2_q;
  logic [23:0] yl2_q;
  logic [17:0] q0s_q;
  logic [12:0] q0h_q;
  logic [16:0] q0l_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      zero2_q <= zero1_q;
      neg2_q  <= neg1_q;
      sec2_q  <= sec1_q;
      d2_q    <= d1_q;
      den2_q  <= den1_q;
      xs2_q   <= xs1_q;
      xh2_q   <= xh1_q;
      yl2_q   <= yl1_q;
      q0s_q   <= prod_s[RCP_K +: 18];
      q0h_q   <= prod_h[RCP_K +: 13];
      q0l_q   <= prod_l[RCP_K +: 17];
    end
  end

  // Stage 3: remainder check, bump quotient where it fell short
  logic [25:0] rem_s;
  logic [20:0] rem_h;
  logic [23:0] rem_l;

  assign rem_s = 26'(xs2_q) - 26'(q0s_q) * 26'(den2_q);
  assign rem_h = xh2_q - 21'(q0h_q) * 21'(d2_q);
  assign rem_l = yl2_q - 24'(q0l_q) * 24'(CHAN_MAX);

  logic        zero3_q, neg3_q;
  sector_e     sec3_q;
  logic [17:0] qs3_q;
  logic [12:0] qh3_q;
  logic [16:0] ql3_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      zero3_q <= zero2_q;
      neg3_q  <= neg2_q;
      sec3_q  <= sec2_q;
      qs3_q   <= (rem_s >= 26'(den2_q)) ? q0s_q + 18'd1 : q0s_q;
      qh3_q   <= (rem_h >= 21'(d2_q)) ? q0h_q + 13'd1 : q0h_q;
      ql3_q   <= (rem_l >= 24'(CHAN_MAX)) ? q0l_q + 17'd1 : q0l_q;
    end
  end

  // Stage 4: halve with rounding, place hue in its sector
  logic [18:0] s_rnd;
  logic [13:0] h_rnd;
  logic [16:0] s_val;
  logic [11:0] hq;
  logic [14:0] hue_d;

  always_comb begin
    s_rnd = 19'(qs3_q) + 19'd1;
    h_rnd = 14'(qh3_q) + 14'd1;
    s_val = s_rnd[17:1];
    hq    = h_rnd[12:1];
    case (sec3_q)
      SEC_RED: begin
        if (neg3_q && hq != 12'd0) hue_d = 15'(TURN) - 15'(hq);
        else if (neg3_q)           hue_d = '0;
        else                       hue_d = 15'(hq);
      end
      SEC_GREEN: hue_d = neg3_q ? 15'(HUE_THIRD) - 15'(hq) : 15'(HUE_THIRD) + 15'(hq);
      SEC_BLUE: begin
        hue_d = neg3_q ? 15'(HUE_TWO_THIRDS) - 15'(hq) : 15'(HUE_TWO_THIRDS) + 15'(hq);
      end
      default: hue_d = '0;
    endcase
  end

  hsl_t out_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      out_q.hue <= zero3_q ? '0 : hue_d;
      out_q.sat <= zero3_q ? '0 : $signed({5'd0, s_val});
      out_q.lit <= $signed({5'd0, ql3_q});
    end
  end

  assign out_data_o = out_q;

`ifndef SYNTHESIS
  a_front_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> (out_q.hue < 15'(TURN)) && !out_q.sat[21]
               && (out_q.sat <= 22'sd65536) && (out_q.lit <= 22'sd65536))
    else $error("front end result out of range");
`endif

endmodule

// ===== rtl/hbca_band.sv =====
// One hue band: distance, triangular weight and offset update in three stages.
// Depends on hbca_pkg.
`timescale 1ns / 1ps

module hbca_band (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [14:0]        center_i,
  input  logic signed [7:0]  hue_off_i,
  input  logic signed [7:0]  sat_off_i,
  input  logic signed [7:0]  lit_off_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hbca_pkg::hsl_t     in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hbca_pkg::hsl_t     out_data_o
);
  import hbca_pkg::*;

  logic [2:0] v_q;
  logic [2:0] en;

  always_comb begin
    en[2] = !v_q[2] || out_ready_i;
    en[1] = !v_q[1] || en[2];
    en[0] = !v_q[0] || en[1];
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  // Stage 1: short-way distance to the center and weighted offsets
  logic signed [15:0] hdiff;
  logic [14:0]        dist_mod, dist_s;
  logic [10:0]        wgt;
  logic signed [19:0] wgt_s;

  always_comb begin
    hdiff    = $signed({1'b0, in_data_i.hue}) - $signed({1'b0, center_i});
    dist_mod = hdiff[15] ? 15'(hdiff + 16'(TURN)) : hdiff[14:0];
    dist_s   = (dist_mod > 15'(HALF_TURN)) ? 15'(TURN) - dist_mod : dist_mod;
    wgt      = (dist_s < 15'(BAND_REACH)) ? 11'(15'(BAND_REACH) - dist_s) : '0;
    wgt_s    = $signed(20'(wgt));
  end

  hsl_t               d1_q;
  logic signed [19:0] ph_q, ps_q, pl_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      d1_q <= in_data_i;
      ph_q <= 20'(hue_off_i) * wgt_s;
      ps_q <= 20'(sat_off_i) * wgt_s;
      pl_q <= 20'(lit_off_i) * wgt_s;
    end
  end

  // Stage 2: rounded division of the magnitudes by a fixed reciprocal
  logic [17:0] mag_h, mag_s, mag_l;
  logic [18:0] xh;
  logic [20:0] xs, xl;
  logic [40:0] prod_h;
  logic [43:0] prod_s, prod_l;

  always_comb begin
    mag_h  = ph_q[19] ? 18'(-ph_q) : ph_q[17:0];
    mag_s  = ps_q[19] ? 18'(-ps_q) : ps_q[17:0];
    mag_l  = pl_q[19] ? 18'(-pl_q) : pl_q[17:0];
    xh     = 19'(mag_h) + 19'(HUE_STEP_DIV / 2);
    xs     = 21'({mag_s, 2'b00}) + 21'(LEVEL_STEP_DIV / 2);
    xl     = 21'({mag_l, 2'b00}) + 21'(LEVEL_STEP_DIV / 2);
    prod_h = 41'(xh) * 41'(RCP_30);
    prod_s = 44'(xs) * 44'(RCP_15);
    prod_l = 44'(xl) * 44'(RCP_15);
  end

  hsl_t        d2_q;
  logic        nh_q, ns_q, nl_q;
  logic [13:0] dh_q;
  logic [16:0] ds_q, dl_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      d2_q <= d1_q;
      nh_q <= ph_q[19];
      ns_q <= ps_q[19];
      nl_q <= pl_q[19];
      dh_q <= prod_h[RCP_SH +: 14];
      ds_q <= prod_s[RCP_SH +: 17];
      dl_q <= prod_l[RCP_SH +: 17];
    end
  end

  // Stage 3: apply offsets, keep hue on the circle
  logic signed [16:0] dh_s, hsum;
  logic signed [21:0] ds_s, dl_s;
  logic [14:0]        hue_d;

  always_comb begin
    dh_s  = nh_q ? -$signed({3'b0, dh_q}) : $signed({3'b0, dh_q});
    ds_s  = ns_q ? -$signed({5'b0, ds_q}) : $signed({5'b0, ds_q});
    dl_s  = nl_q ? -$signed({5'b0, dl_q}) : $signed({5'b0, dl_q});
    hsum  = $signed({2'b0, d2_q.hue}) + dh_s;
    if (hsum[16])                            hue_d = 15'(hsum + 17'(TURN));
    else if ($unsigned(hsum) >= 17'(TURN))   hue_d = 15'(hsum - 17'(TURN));
    else                                     hue_d = hsum[14:0];
  end

  hsl_t out_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      out_q.hue <= hue_d;
      out_q.sat <= d2_q.sat + ds_s;
      out_q.lit <= d2_q.lit + dl_s;
    end
  end

  assign out_data_o = out_q;

`ifndef SYNTHESIS
  a_band_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] |-> out_q.hue < 15'(TURN))
    else $error("band hue left the circle");
`endif

endmodule

// ===== rtl/hbca_hsl2rgb.sv =====
// HSL to RGB back end: clamp, chroma terms, per-channel ramps and byte output
// over six pipeline stages. Depends on hbca_pkg.
`timescale 1ns / 1ps

module hbca_hsl2rgb (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hbca_pkg::hsl_t     in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hbca_pkg::rgb_out_t out_data_o
);
  import hbca_pkg::*;

  function automatic logic [16:0] clamp_unit(input logic signed [21:0] v);
    logic [16:0] r;
    if (v[21])                  r = '0;
    else if (v > 22'sd65536)    r = 17'(ONE_Q16);
    else                        r = v[16:0];
    return r;
  endfunction

  // Weight of q-p for one channel hue: rising, flat, falling, zero
  function automatic logic [11:0] ramp(input logic [14:0] t);
    logic [11:0] r;
    if (t < 15'(HUE_SECTOR))          r = 12'(t);
    else if (t < 15'(HALF_TURN))      r = 12'(HUE_SECTOR);
    else if (t < 15'(HUE_TWO_THIRDS)) r = 12'(15'(HUE_TWO_THIRDS) - t);
    else                              r = '0;
    return r;
  endfunction

  function automatic logic [7:0] to_byte(input logic signed [20:0] v);
    logic [28:0] sc;
    logic [7:0]  r;
    sc = 29'(v[19:0]) * 29'(CHAN_MAX) + 29'(HALF_Q16);
    if (v[20])                    r = '0;
    else if (sc[28:16] > 13'(CHAN_MAX)) r = 8'(CHAN_MAX);
    else                          r = sc[23:16];
    return r;
  endfunction

  logic [5:0] v_q;
  logic [5:0] en;

  always_comb begin
    en[5] = !v_q[5] || out_ready_i;
    en[4] = !v_q[4] || en[5];
    en[3] = !v_q[3] || en[4];
    en[2] = !v_q[2] || en[3];
    en[1] = !v_q[1] || en[2];
    en[0] = !v_q[0] || en[1];
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
      if (en[4]) v_q[4] <= v_q[3];
      if (en[5]) v_q[5] <= v_q[4];
    end
  end

  // Stage 1: clamp levels, channel hues and their ramp weights
  logic [15:0] hr_sum;
  logic [14:0] tr, tb;

  always_comb begin
    hr_sum = 16'(in_data_i.hue) + 16'(HUE_THIRD);
    tr = (hr_sum >= 16'(TURN)) ? 15'(hr_sum - 16'(TURN)) : hr_sum[14:0];
    tb = (in_data_i.hue < 15'(HUE_THIRD)) ? in_data_i.hue + 15'(HUE_TWO_THIRDS)
                                          : in_data_i.hue - 15'(HUE_THIRD);
  end

  logic [16:0] l1_q, s1_q;
  logic [11:0] fr1_q, fg1_q, fb1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      l1_q  <= clamp_unit(in_data_i.lit);
      s1_q  <= clamp_unit(in_data_i.sat);
      fr1_q <= ramp(tr);
      fg1_q <= ramp(in_data_i.hue);
      fb1_q <= ramp(tb);
    end
  end

  // Stage 2: L*S
  logic [16:0] l2_q, s2_q;
  logic [11:0] fr2_q, fg2_q, fb2_q;
  logic [33:0] ls2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      l2_q  <= l1_q;
      s2_q  <= s1_q;
      fr2_q <= fr1_q;
      fg2_q <= fg1_q;
      fb2_q <= fb1_q;
      ls2_q <= 34'(l1_q) * 34'(s1_q);
    end
  end

  // Stage 3: q, p and the span q - p
  logic [33:0]        ls_rnd;
  logic [16:0]        rls;
  logic [17:0]        qv;
  logic signed [19:0] pv, span;

  always_comb begin
    ls_rnd = ls2_q + 34'(HALF_Q16);
    rls    = ls_rnd[32:16];
    if (l2_q < 17'(HALF_Q16)) qv = 18'(l2_q) + 18'(rls);
    else                      qv = 18'(l2_q) + 18'(s2_q) - 18'(rls);
    pv   = $signed({2'b0, l2_q, 1'b0}) - $signed({2'b0, qv});
    span = $signed({2'b0, qv}) - pv;
  end

  logic signed [19:0] p3_q, span3_q;
  logic [11:0]        fr3_q, fg3_q, fb3_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      p3_q    <= pv;
      span3_q <= span;
      fr3_q   <= fr2_q;
      fg3_q   <= fg2_q;
      fb3_q   <= fb2_q;
    end
  end

  // Stage 4: span times ramp weight
  logic signed [19:0] p4_q;
  logic [29:0]        mr4_q, mg4_q, mb4_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      p4_q  <= p3_q;
      mr4_q <= 30'(span3_q[17:0]) * 30'(fr3_q);
      mg4_q <= 30'(span3_q[17:0]) * 30'(fg3_q);
      mb4_q <= 30'(span3_q[17:0]) * 30'(fb3_q);
    end
  end

  // Stage 5: rounded divide by the sector width (256 * 15)
  logic [29:0] mr_rnd, mg_rnd, mb_rnd;
  logic [44:0] pr, pg, pb;

  always_comb begin
    mr_rnd = mr4_q + 30'(HUE_SECTOR / 2);
    mg_rnd = mg4_q + 30'(HUE_SECTOR / 2);
    mb_rnd = mb4_q + 30'(HUE_SECTOR / 2);
    pr = 45'(mr_rnd[29:8]) * 45'(RCP_15);
    pg = 45'(mg_rnd[29:8]) * 45'(RCP_15);
    pb = 45'(mb_rnd[29:8]) * 45'(RCP_15);
  end

  logic signed [19:0] p5_q;
  logic [17:0]        vr5_q, vg5_q, vb5_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      p5_q  <= p4_q;
      vr5_q <= pr[RCP_SH +: 18];
      vg5_q <= pg[RCP_SH +: 18];
      vb5_q <= pb[RCP_SH +: 18];
    end
  end

  // Stage 6: add p, scale to a byte
  rgb_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      out_q.red_out   <= to_byte(21'(p5_q) + $signed({3'b0, vr5_q}));
      out_q.green_out <= to_byte(21'(p5_q) + $signed({3'b0, vg5_q}));
      out_q.blue_out  <= to_byte(21'(p5_q) + $signed({3'b0, vb5_q}));
    end
  end

  assign out_data_o = out_q;

`ifndef SYNTHESIS
  a_span_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] |-> !span3_q[19] && (span3_q <= 20'sd131072))
    else $error("chroma span negative or too wide");
`endif

endmodule

// ===== rtl/hsl_band_color_adjust_unit.sv =====
// Top level of the HSL band color adjust unit: configuration registers,
// front end, eight band stages and back end. Depends on hbca_pkg and submodules.
//
//  channel   handshake                 payload
//  input     in_valid_i / in_ready_o   in_data_i  (red_in, green_in, blue_in)
//  output    out_valid_o / out_ready_i out_data_o (red_out, green_out, blue_out)
//  config    cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// One item per cycle sustained while the output is not stalled; 4 front-end stages,
// 3 stages per band for 8 bands (hue feeds the next band), 6 back-end stages.
// Reset clears the offset registers and all valid bits; no clearing pass.
// Each stage holds while the one after it is full and stalled; bubbles fill.
`timescale 1ns / 1ps

module hsl_band_color_adjust_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hbca_pkg::rgb_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hbca_pkg::rgb_out_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_wdata_i
);
  import hbca_pkg::*;

  logic [63:0] hue_off_q, sat_off_q, lit_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_off_q <= '0;
      sat_off_q <= '0;
      lit_off_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_HUE: hue_off_q <= cfg_wdata_i;
        CFG_SAT: sat_off_q <= cfg_wdata_i;
        CFG_LIT: lit_off_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  hsl_t                 band_data  [NUM_BANDS+1];
  logic [NUM_BANDS:0]   band_valid;
  logic [NUM_BANDS:0]   band_ready;

  hbca_rgb2hsl u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (band_valid[0]),
    .out_ready_i (band_ready[0]),
    .out_data_o  (band_data[0])
  );

  for (genvar i = 0; i < NUM_BANDS; i++) begin : g_band
    hbca_band u_band (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .center_i    (BAND_CENTER[i]),
      .hue_off_i   (hue_off_q[8*i +: 8]),
      .sat_off_i   (sat_off_q[8*i +: 8]),
      .lit_off_i   (lit_off_q[8*i +: 8]),
      .in_valid_i  (band_valid[i]),
      .in_ready_o  (band_ready[i]),
      .in_data_i   (band_data[i]),
      .out_valid_o (band_valid[i+1]),
      .out_ready_i (band_ready[i+1]),
      .out_data_o  (band_data[i+1])
    );
  end

  hbca_hsl2rgb u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (band_valid[NUM_BANDS]),
    .in_ready_o  (band_ready[NUM_BANDS]),
    .in_data_i   (band_data[NUM_BANDS]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input held back while output side drains");

  a_cfg_ignore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_index_i != CFG_HUE) |=> $stable(hue_off_q))
    else $error("hue offsets changed by a write to another register");
`endif

endmodule
